// ===== rtl/core/integer_to_roman_numeral_core_assert.svh =====
// ----------------------------------------------------------------------------
// Roman numeral core assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define I2R_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg
// Types, microcode and symbol tables of the Roman numeral core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

    localparam int NUM_W   = 12;
    localparam int SYM_W   = 7;
    localparam int DIGIT_W = 4;
    localparam int PLACE_W = 2;
    localparam int PROD_W  = 14;

    localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;

    localparam logic [SYM_W-1:0] CH_I = 7'h49;
    localparam logic [SYM_W-1:0] CH_V = 7'h56;
    localparam logic [SYM_W-1:0] CH_X = 7'h58;
    localparam logic [SYM_W-1:0] CH_L = 7'h4C;
    localparam logic [SYM_W-1:0] CH_C = 7'h43;
    localparam logic [SYM_W-1:0] CH_D = 7'h44;
    localparam logic [SYM_W-1:0] CH_M = 7'h4D;
    localparam logic [SYM_W-1:0] CH_NUL = 7'h00;

    typedef logic [2:0] t_upc;
    typedef logic [1:0] t_sym;
    typedef logic [1:0] t_dec;
    typedef logic [2:0] t_jc;

    // sequencer steps
    localparam t_upc S_LOAD  = 3'd0;
    localparam t_upc S_ONES  = 3'd1;
    localparam t_upc S_FIVE  = 3'd2;
    localparam t_upc S_PRE   = 3'd3;
    localparam t_upc S_FOURB = 3'd4;
    localparam t_upc S_NINEB = 3'd5;
    localparam t_upc S_ERR   = 3'd6;

    // symbol select within a place
    localparam t_sym SYM_ONE  = 2'd0;
    localparam t_sym SYM_FIVE = 2'd1;
    localparam t_sym SYM_TEN  = 2'd2;

    // digit register update
    localparam t_dec DEC_NONE = 2'd0;
    localparam t_dec DEC_ONE  = 2'd1;
    localparam t_dec DEC_FIVE = 2'd2;
    localparam t_dec DEC_LOAD = 2'd3;

    // jump conditions
    localparam t_jc JC_END      = 3'd0;
    localparam t_jc JC_DISPATCH = 3'd1;
    localparam t_jc JC_ONES     = 3'd2;
    localparam t_jc JC_FIVE     = 3'd3;
    localparam t_jc JC_PAIR     = 3'd4;

    typedef struct packed {
        logic emit;
        logic err;
        t_sym sym;
        t_dec dec;
        t_jc  jc;
        t_upc target;
    } t_cw;

    function automatic t_cw ucode(input t_upc a);
        t_cw cw;
        cw = '{emit: 1'b0, err: 1'b0, sym: SYM_ONE, dec: DEC_NONE,
               jc: JC_END, target: S_LOAD};
        case (a)
            S_LOAD: begin
                cw.dec = DEC_LOAD;
                cw.jc  = JC_DISPATCH;
            end
            S_ONES: begin
                cw.emit   = 1'b1;
                cw.dec    = DEC_ONE;
                cw.jc     = JC_ONES;
                cw.target = S_ONES;
            end
            S_FIVE: begin
                cw.emit   = 1'b1;
                cw.sym    = SYM_FIVE;
                cw.dec    = DEC_FIVE;
                cw.jc     = JC_FIVE;
                cw.target = S_ONES;
            end
            S_PRE: begin
                cw.emit = 1'b1;
                cw.jc   = JC_PAIR;
            end
            S_FOURB: begin
                cw.emit = 1'b1;
                cw.sym  = SYM_FIVE;
            end
            S_NINEB: begin
                cw.emit = 1'b1;
                cw.sym  = SYM_TEN;
            end
            S_ERR: begin
                cw.emit = 1'b1;
                cw.err  = 1'b1;
            end
            default: begin
                cw.jc = JC_END;
            end
        endcase
        return cw;
    endfunction

    function automatic logic [PROD_W-1:0] place_val(input logic [PLACE_W-1:0] p);
        logic [PROD_W-1:0] v;
        case (p)
            2'd0:    v = 14'd1000;
            2'd1:    v = 14'd100;
            2'd2:    v = 14'd10;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

    // leading digit of a residue known to be below ten place units
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [NUM_W-1:0] r,
                                                    input logic [PLACE_W-1:0] p);
        logic [DIGIT_W-1:0] q;
        logic [PROD_W-1:0]  pv;
        q  = '0;
        pv = place_val(p);
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r} >= PROD_W'(k) * pv) begin
                q = DIGIT_W'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [SYM_W-1:0] sym_char(input logic [PLACE_W-1:0] p,
                                                  input t_sym s);
        logic [SYM_W-1:0] c;
        case (p)
            2'd0: c = CH_M;
            2'd1: c = (s == SYM_ONE) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
            2'd2: c = (s == SYM_ONE) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
            default: c = (s == SYM_ONE) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_roman_numeral_core.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral core
// Converts a 12-bit number into its Roman numeral as ASCII words, one number at a time.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_stall   i_number[11:0]
// out      out  o_out_valid / i_out_stall o_symbol[6:0], o_last, o_out_of_range
//
// An item is accepted, then the microcode sequencer, which runs one control word
// per cycle while no emit step waits, takes a load step for each place up to the
// last nonzero one and an emit step for each character.
// Reset is synchronous, active low; it empties the sequencer and output word.
// An emit step waits while the output word is held by i_out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral_core
    import i2r_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire  [NUM_W-1:0]  i_number,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [SYM_W-1:0]  o_symbol,
    output logic              o_last,
    output logic              o_out_of_range
);

    logic                r_busy,  n_busy;
    t_upc                r_upc,   n_upc;
    logic [PLACE_W-1:0]  r_place, n_place;
    logic [DIGIT_W-1:0]  r_digit, n_digit;
    logic [NUM_W-1:0]    r_rem,   n_rem;
    logic                r_out_vld;
    logic [SYM_W-1:0]    r_sym;
    logic                r_last;
    logic                r_oor;

    t_cw                 cw;
    logic [DIGIT_W-1:0]  q;
    logic [PROD_W-1:0]   sub;
    logic                in_acc;
    logic                in_err;
    logic                out_free;
    logic                step;
    logic                do_emit;
    logic                dig_end;

    assign cw       = ucode(r_upc);
    assign q        = digit_of(r_rem, r_place);
    assign sub      = PROD_W'(q) * place_val(r_place);
    assign in_acc   = i_in_valid && !r_busy;
    assign in_err   = (i_number == '0) || (i_number > NUM_MAX);
    assign out_free = !r_out_vld || !i_out_stall;
    assign step     = r_busy && (!cw.emit || out_free);
    assign do_emit  = step && cw.emit;

    always_comb begin
        n_busy  = r_busy;
        n_upc   = r_upc;
        n_place = r_place;
        n_digit = r_digit;
        n_rem   = r_rem;
        dig_end = 1'b0;
        if (in_acc) begin
            n_busy  = 1'b1;
            n_place = '0;
            n_rem   = in_err ? '0 : i_number;
            n_upc   = in_err ? S_ERR : S_LOAD;
        end else if (step) begin
            case (cw.dec)
                DEC_LOAD: begin
                    n_digit = q;
                    n_rem   = r_rem - sub[NUM_W-1:0];
                end
                DEC_ONE:  n_digit = r_digit - 4'd1;
                DEC_FIVE: n_digit = r_digit - 4'd5;
                default:  n_digit = r_digit;
            endcase
            case (cw.jc)
                JC_DISPATCH: begin
                    if (q == '0) begin
                        n_place = r_place + 2'd1;
                        n_upc   = S_LOAD;
                    end else if (q inside {4'd4, 4'd9}) begin
                        n_upc = S_PRE;
                    end else if (q >= 4'd5) begin
                        n_upc = S_FIVE;
                    end else begin
                        n_upc = S_ONES;
                    end
                end
                JC_ONES: begin
                    if (r_digit == 4'd1) dig_end = 1'b1;
                    else                 n_upc   = cw.target;
                end
                JC_FIVE: begin
                    if (r_digit == 4'd5) dig_end = 1'b1;
                    else                 n_upc   = cw.target;
                end
                JC_PAIR: n_upc = (r_digit == 4'd4) ? S_FOURB : S_NINEB;
                default: dig_end = 1'b1;
            endcase
            if (dig_end) begin
                if (r_rem == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_place = r_place + 2'd1;
                    n_upc   = S_LOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_upc     <= S_LOAD;
            r_out_vld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
            if (out_free) begin
                r_out_vld <= do_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_place <= n_place;
        r_digit <= n_digit;
        r_rem   <= n_rem;
        if (do_emit) begin
            r_sym  <= cw.err ? CH_NUL : sym_char(r_place, cw.sym);
            r_last <= dig_end && (r_rem == '0);
            r_oor  <= cw.err;
        end
    end

    assign o_in_stall     = r_busy;
    assign o_out_valid    = r_out_vld;
    assign o_symbol       = r_sym;
    assign o_last         = r_last;
    assign o_out_of_range = r_oor;

endmodule

`default_nettype wire

// ===== rtl/core/i2r_checker.sv =====
// ----------------------------------------------------------------------------
// i2r_checker
// Port-level checks of the Roman numeral core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_roman_numeral_core_assert.svh"

module i2r_checker
    import i2r_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              o_in_stall,
    input wire [NUM_W-1:0]  i_number,
    input wire              o_out_valid,
    input wire              i_out_stall,
    input wire [SYM_W-1:0]  o_symbol,
    input wire              o_last,
    input wire              o_out_of_range
);

    `I2R_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "out word dropped")

    `I2R_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_symbol) && $stable(o_last) && $stable(o_out_of_range), "out word changed")

    `I2R_ASSERT_NEXT(a_in_busy, i_in_valid && !o_in_stall && (i_number == i_number), o_in_stall, "accept did not start sequencer")

    `I2R_ASSERT_NOW(a_err_word, o_out_valid && o_out_of_range, o_last && (o_symbol == CH_NUL), "bad error word")

    `I2R_ASSERT_NOW(a_sym_set, o_out_valid && !o_out_of_range, (o_symbol == CH_I) || (o_symbol == CH_V) || (o_symbol == CH_X) || (o_symbol == CH_L) || (o_symbol == CH_C) || (o_symbol == CH_D) || (o_symbol == CH_M), "bad symbol")

endmodule

bind integer_to_roman_numeral_core i2r_checker u_i2r_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_number       (i_number),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_symbol       (o_symbol),
    .o_last         (o_last),
    .o_out_of_range (o_out_of_range)
);

`default_nettype wire
